@@ rtl/smr_pkg.sv @@
// Shared constants, types and helpers for the spiral matrix reorder block.
`timescale 1ns / 1ps
`default_nettype none
package smr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int ADDR_W      = IDX_W + 1;          // one bank bit on top
  localparam int CNT_W       = IDX_W + 1;
  localparam int SIZE_W      = 4;
  localparam int PROD_W      = 2 * SIZE_W;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int LIN_W       = ROW_W + SIZE_W;
  localparam int VALUE_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = OUT_PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_MAX_ROWS = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] SIZE_MAX_COLS = SIZE_W'(MAX_COLS);

  // One finished load waiting to be walked.
  typedef struct packed {
    logic              bank;
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } walk_cmd_t;

  // Position and end mark that travel alongside a store read.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } result_tag_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    result_tag_t        tag;
  } result_t;

  // Zero counts as one, anything above the maximum as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/smr_store.sv @@
// Two-bank element store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module smr_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [smr_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [smr_pkg::VALUE_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [smr_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [smr_pkg::VALUE_W-1:0] rd_data
);
  import smr_pkg::*;

  logic [VALUE_W-1:0] mem_r [2*STORE_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/smr_walk_q.sv @@
// Two-entry queue of finished loads between the load side and the walker.
`timescale 1ns / 1ps
`default_nettype none
module smr_walk_q (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire smr_pkg::walk_cmd_t push_cmd,
  input  wire logic               pop,
  output smr_pkg::walk_cmd_t      head_cmd,
  output logic                    full,
  output logic                    empty
);
  import smr_pkg::*;

  walk_cmd_t ent_r [2];
  logic      wr_ptr_r, wr_ptr_nxt;
  logic      rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_cmd = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/smr_front.sv @@
// Load side: size registers, element intake, bank selection and load completion.
`timescale 1ns / 1ps
`default_nettype none
module smr_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [smr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [smr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic signed [smr_pkg::VALUE_W-1:0] in_element_value,
  input  wire logic                           q_full,
  output logic                                q_push,
  output smr_pkg::walk_cmd_t                  q_cmd,
  output logic                                st_wr_en,
  output logic      [smr_pkg::ADDR_W-1:0]     st_wr_addr,
  output logic      [smr_pkg::VALUE_W-1:0]    st_wr_data
);
  import smr_pkg::*;

  logic [SIZE_W-1:0] row_count_r, row_count_nxt;
  logic [SIZE_W-1:0] column_count_r, column_count_nxt;
  logic [IDX_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic              bank_r, bank_nxt;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] cols;
  logic [PROD_W-1:0] total;
  logic [CNT_W-1:0]  cnt_inc;
  logic              take;
  logic              load_done;

  assign cfg_ready = 1'b1;
  // Both banks hold loads not yet walked: nowhere to put the next element.
  assign in_full   = q_full;
  assign take      = in_push && !q_full;

  assign rows      = clamp_size(row_count_r, SIZE_MAX_ROWS);
  assign cols      = clamp_size(column_count_r, SIZE_MAX_COLS);
  assign total     = rows * cols;
  assign cnt_inc   = {1'b0, load_cnt_r} + CNT_W'(1);
  assign load_done = (PROD_W'(cnt_inc) >= total);

  assign st_wr_en   = take;
  assign st_wr_addr = {bank_r, load_cnt_r};
  assign st_wr_data = in_element_value;

  assign q_push = take && load_done;
  assign q_cmd  = '{bank: bank_r, rows: rows, cols: cols};

  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    if (cfg_valid) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count_nxt = cfg_data;
      end else if (cfg_index == REG_COLUMN_COUNT) begin
        column_count_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    bank_nxt     = bank_r;
    if (take) begin
      if (load_done) begin
        load_cnt_nxt = '0;
        bank_nxt     = ~bank_r;
      end else begin
        load_cnt_nxt = cnt_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= SIZE_W'(MAX_ROWS);
      column_count_r <= SIZE_W'(MAX_COLS);
      load_cnt_r     <= '0;
      bank_r         <= 1'b0;
    end else begin
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
      load_cnt_r     <= load_cnt_nxt;
      bank_r         <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/smr_back.sv @@
// Walk side: clockwise spiral address generator, store reads and result queue.
`timescale 1ns / 1ps
`default_nettype none
module smr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire smr_pkg::walk_cmd_t          q_head,
  output logic                             q_pop,
  output logic                             st_rd_en,
  output logic      [smr_pkg::ADDR_W-1:0]  st_rd_addr,
  input  wire logic [smr_pkg::VALUE_W-1:0] st_rd_data,
  input  wire logic                        out_pop,
  output logic                             out_empty,
  output smr_pkg::result_t                 out_result
);
  import smr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  typedef enum logic [3:0] {
    DIR_RIGHT = 4'b0001,
    DIR_DOWN  = 4'b0010,
    DIR_LEFT  = 4'b0100,
    DIR_UP    = 4'b1000
  } dir_t;

  state_t            state_r, state_nxt;
  dir_t              dir_r, dir_nxt;
  logic              bank_r, bank_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  bot_r, bot_nxt;
  logic [COL_W-1:0]  left_r, left_nxt;
  logic [COL_W-1:0]  right_r, right_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  last_idx_r, last_idx_nxt;

  logic              inflight_r;
  result_tag_t       tag_r;

  result_t           fifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;

  logic              can_issue;
  logic              issue;
  logic              at_last;
  logic [LIN_W-1:0]  lin;
  logic [PROD_W-1:0] head_total;
  logic              fifo_pop;

  // Keep room for every read in flight plus the one about to start.
  assign can_issue  = (cnt_r + OUT_CNT_W'(inflight_r)) < OUT_CNT_W'(OUT_DEPTH);
  assign issue      = (state_r == ST_WALK) && can_issue;
  assign at_last    = (k_r == last_idx_r);
  assign lin        = row_r * cols_r + LIN_W'(col_r);
  assign head_total = q_head.rows * q_head.cols;

  assign st_rd_en   = issue;
  assign st_rd_addr = {bank_r, lin[IDX_W-1:0]};
  // Bank is released as its final read goes out.
  assign q_pop      = issue && at_last;

  always_comb begin
    state_nxt    = state_r;
    dir_nxt      = dir_r;
    bank_nxt     = bank_r;
    cols_nxt     = cols_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    k_nxt        = k_r;
    last_idx_nxt = last_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt    = ST_WALK;
          dir_nxt      = DIR_RIGHT;
          bank_nxt     = q_head.bank;
          cols_nxt     = q_head.cols;
          row_nxt      = '0;
          col_nxt      = '0;
          top_nxt      = '0;
          bot_nxt      = ROW_W'(q_head.rows - SIZE_W'(1));
          left_nxt     = '0;
          right_nxt    = COL_W'(q_head.cols - SIZE_W'(1));
          k_nxt        = '0;
          last_idx_nxt = IDX_W'(head_total - PROD_W'(1));
        end
      end
      ST_WALK: begin
        if (issue) begin
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + IDX_W'(1);
            // Move on until blocked by a bound, then turn clockwise and
            // retire the side just finished.
            unique case (dir_r)
              DIR_RIGHT: begin
                if (col_r < right_r) begin
                  col_nxt = col_r + COL_W'(1);
                end else begin
                  dir_nxt = DIR_DOWN;
                  top_nxt = top_r + ROW_W'(1);
                  row_nxt = row_r + ROW_W'(1);
                end
              end
              DIR_DOWN: begin
                if (row_r < bot_r) begin
                  row_nxt = row_r + ROW_W'(1);
                end else begin
                  dir_nxt   = DIR_LEFT;
                  right_nxt = right_r - COL_W'(1);
                  col_nxt   = col_r - COL_W'(1);
                end
              end
              DIR_LEFT: begin
                if (col_r > left_r) begin
                  col_nxt = col_r - COL_W'(1);
                end else begin
                  dir_nxt = DIR_UP;
                  bot_nxt = bot_r - ROW_W'(1);
                  row_nxt = row_r - ROW_W'(1);
                end
              end
              DIR_UP: begin
                if (row_r > top_r) begin
                  row_nxt = row_r - ROW_W'(1);
                end else begin
                  dir_nxt  = DIR_RIGHT;
                  left_nxt = left_r + COL_W'(1);
                  col_nxt  = col_r + COL_W'(1);
                end
              end
              default: begin
                dir_nxt = DIR_RIGHT;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dir_r      <= DIR_RIGHT;
      inflight_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dir_r      <= dir_nxt;
      inflight_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    bank_r     <= bank_nxt;
    cols_r     <= cols_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    k_r        <= k_nxt;
    last_idx_r <= last_idx_nxt;
    if (issue) begin
      tag_r.row  <= row_r;
      tag_r.col  <= col_r;
      tag_r.last <= at_last;
    end
  end

  // Result queue; store data and its tag arrive together in the cycle after issue.
  assign fifo_pop   = out_pop && (cnt_r != '0);
  assign out_empty  = (cnt_r == '0);
  assign out_result = fifo_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (inflight_r && !fifo_pop) begin
      cnt_nxt = cnt_r + OUT_CNT_W'(1);
    end else if (fifo_pop && !inflight_r) begin
      cnt_nxt = cnt_r - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (inflight_r) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inflight_r) begin
      fifo_r[wr_ptr_r].value <= st_rd_data;
      fifo_r[wr_ptr_r].tag   <= tag_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/spiral_matrix_reorder.sv @@
// Top level of the spiral matrix reorder block.
`timescale 1ns / 1ps
`default_nettype none
// Matrix elements are pushed in row-major order; after the last element of a
// row_count x column_count matrix (each clamped to 1..8) the block produces
// every element in clockwise spiral order with its row, column and a mark on
// the final one. The store has two banks: one fills while the other is walked,
// so an element is taken whenever in_full is low and the walk delivers one
// result per cycle when pop keeps up, idling between walks. A walk's first
// result reaches the out_ ports via the queue hand-off, walk start, store
// read and result queue write after the transfer completing its matrix.
// in_full rises only while both banks hold matrices not yet walked. Sizes
// are sampled on every transfer and the fill count survives a size change;
// a size write is expected only while the block is idle. The config port is
// always ready; indexes other than 0 (rows) and 1 (columns) are ignored.
module spiral_matrix_reorder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [smr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [smr_pkg::CFG_DATA_W-1:0] cfg_data,
  // element input
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic signed [smr_pkg::VALUE_W-1:0] in_element_value,
  // spiral results
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic signed [smr_pkg::VALUE_W-1:0]  out_value,
  output logic [smr_pkg::ROW_W-1:0]           out_row,
  output logic [smr_pkg::COL_W-1:0]           out_column,
  output logic                                out_last_of_walk
);
  import smr_pkg::*;

  walk_cmd_t           q_push_cmd;
  walk_cmd_t           q_head;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic                st_wr_en;
  logic [ADDR_W-1:0]   st_wr_addr;
  logic [VALUE_W-1:0]  st_wr_data;
  logic                st_rd_en;
  logic [ADDR_W-1:0]   st_rd_addr;
  logic [VALUE_W-1:0]  st_rd_data;
  result_t             result;

  // Load side: registers, intake, load completion.
  smr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_element_value (in_element_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_push_cmd),
    .st_wr_en         (st_wr_en),
    .st_wr_addr       (st_wr_addr),
    .st_wr_data       (st_wr_data)
  );

  // Finished loads waiting for the walker, one per bank.
  smr_walk_q u_walk_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  smr_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Walk side: spiral order, store reads, result queue.
  smr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .st_rd_en   (st_rd_en),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_result (result)
  );

  assign out_value        = result.value;
  assign out_row          = result.tag.row;
  assign out_column       = result.tag.col;
  assign out_last_of_walk = result.tag.last;

endmodule
`default_nettype wire
